// ===== src/srd_pkg.sv =====
// Shared types, codes and helper functions for the rotating scroll display controller.
// Used by the slot store and the top level; depends on nothing else.
`timescale 1ns / 1ps

package srd_pkg;

    localparam int DIGITS = 4;
    localparam int CODE_W = 8;
    localparam int TICK_W = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Segment bit 7 is the colon or dot, active low.
    localparam logic [CODE_W-1:0] COLON_BIT = 8'h80;
    localparam logic [CODE_W-1:0] COLON_MASK = 8'h7F;

    // Register values after reset.
    localparam logic [TICK_W-1:0] SLOT_DUR_RST = 16'd120;
    localparam logic [TICK_W-1:0] SCROLL_DUR_RST = 16'd7;
    localparam logic SCROLL_MODE_RST = 1'b1;
    localparam logic [7:0] BLANK_CNT_RST = 8'd2;
    localparam logic SHOW_COLON_RST = 1'b1;
    localparam logic [TICK_W-1:0] TICK_RST = 16'hFFFF;
    localparam logic [7:0] NO_SLOT = 8'hFF;

    // Request types.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_DUR = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCROLL_DUR = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCROLL_MODE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLANK_CNT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHOW_COLON = 3'd4;

    // Four segment codes, index 0 is the leftmost digit.
    typedef logic [DIGITS-1:0][CODE_W-1:0] t_codes;

    // Display phase.
    typedef enum logic [2:0] {
        PH_DISPLAY = 3'd0,
        PH_BLANK   = 3'd1,
        PH_DIG1    = 3'd2,
        PH_DIG2    = 3'd3,
        PH_DIG3    = 3'd4
    } t_phase;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_EXEC   = 3'd1,
        ST_SEARCH = 3'd2,
        ST_APPLY  = 3'd3,
        ST_DONE   = 3'd4
    } t_state;

    // Write port of the slot store.
    typedef struct packed {
        logic       en;
        logic [2:0] idx;
        logic       enabled;
        t_codes     codes;
    } t_slot_wr;

    // Light the colon by clearing bit 7 of the two leftmost digits.
    function automatic t_codes apply_colon(input t_codes codes, input logic on);
        t_codes res;
        res = codes;
        if (on) begin
            res[0] = codes[0] & COLON_MASK;
            res[1] = codes[1] & COLON_MASK;
        end
        return res;
    endfunction

    // Shift the digits left by one and enter a code on the right.
    function automatic t_codes shift_in(input t_codes codes, input logic [CODE_W-1:0] code);
        t_codes res;
        res[0] = codes[1];
        res[1] = codes[2];
        res[2] = codes[3];
        res[3] = code;
        return res;
    endfunction

endpackage

// ===== src/srd_slot_store.sv =====
// Slot store: enable flags and four segment codes per slot, cleared at reset.
// Depends on srd_pkg for the code and write-port types.
`timescale 1ns / 1ps

module srd_slot_store import srd_pkg::*; #(
    parameter int SLOT_COUNT = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_slot_wr              i_wr,
    input  logic [7:0]            i_rd_slot,
    output t_codes                o_rd_codes,
    output logic [SLOT_COUNT-1:0] o_enables
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    t_codes                r_codes [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_enables;

    // At most one entry is written per write transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enables <= '0;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_codes[k] <= '0;
            end
        end else if (i_wr.en) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                if (5'(k) == {2'b00, i_wr.idx}) begin
                    r_codes[k]   <= i_wr.codes;
                    r_enables[k] <= i_wr.enabled;
                end
            end
        end
    end

    // A slot number outside the store, such as none yet, reads as all zero.
    always_comb begin
        if (i_rd_slot < 8'(SLOT_COUNT)) begin
            o_rd_codes = r_codes[i_rd_slot[IDX_W-1:0]];
        end else begin
            o_rd_codes = '0;
        end
    end

    assign o_enables = r_enables;

endmodule

// ===== src/slot_rotating_scroll_display.sv =====
// Top level of the rotating scroll display controller: sequencer, slot search and display state.
// Depends on srd_pkg and instantiates srd_slot_store.
`timescale 1ns / 1ps

// Every input transaction gives exactly one result with the four shown segment codes and the
// scrolling flag. A slot write or a tick that does not end a slot time passes from acceptance
// through the execute and done states to the output register; a tick that ends a slot time also
// runs the next-slot search, one slot per cycle through a single incrementer for 1 to SLOT_COUNT
// slots, and then the apply state. The block takes the next transaction in the cycle after the
// result is registered, even while that result still waits on the output. Configuration writes
// take effect at once and must be issued only while the block is idle.

module slot_rotating_scroll_display import srd_pkg::*; #(
    parameter int          SLOT_COUNT   = 5,
    parameter logic [7:0]  BLANK_CODE   = 8'd255,
    parameter logic [7:0]  POWERUP_CODE = 8'd128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    // Input channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_req_type,
    input  logic [2:0]            i_slot_index,
    input  logic                  i_slot_enabled,
    input  logic [7:0]            i_slot_code_a,
    input  logic [7:0]            i_slot_code_b,
    input  logic [7:0]            i_slot_code_c,
    input  logic [7:0]            i_slot_code_d,
    // Output channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_shown_a,
    output logic [7:0]            o_shown_b,
    output logic [7:0]            o_shown_c,
    output logic [7:0]            o_shown_d,
    output logic                  o_scrolling
);

    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int LEFT_W = $clog2(SLOT_COUNT + 1);

    // Configuration registers
    logic [TICK_W-1:0] r_slot_dur;
    logic [TICK_W-1:0] r_scroll_dur;
    logic              r_scroll_mode;
    logic [7:0]        r_blank_cnt;
    logic              r_show_colon;

    // Sequencer and captured transaction
    t_state            r_state, n_state;
    logic              r_req_type;
    logic [2:0]        r_idx;
    logic              r_en_in;
    t_codes            r_codes_in;

    // Display state
    logic [7:0]        r_cur, n_cur;
    logic [7:0]        r_prev, n_prev;
    logic [LEFT_W-1:0] r_left, n_left;
    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [7:0]        r_blanks, n_blanks;
    t_codes            r_shown, n_shown;

    // Output register
    logic              r_out_valid;
    t_codes            r_out_codes;
    logic              r_out_scroll;

    // Control between the sequencer and the datapath
    logic              load_out;
    logic              tick_due;
    logic              search_go;
    logic              search_stop;
    logic              idx_ok;
    logic [TICK_W-1:0] thresh;
    logic [7:0]        nx_slot;
    logic [LEFT_W-1:0] nx_left;
    t_slot_wr          slot_wr;
    t_codes            slot_codes;
    logic [SLOT_COUNT-1:0] slot_enables;

    srd_slot_store #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (slot_wr),
        .i_rd_slot  (r_cur),
        .o_rd_codes (slot_codes),
        .o_enables  (slot_enables)
    );

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_dur    <= SLOT_DUR_RST;
            r_scroll_dur  <= SCROLL_DUR_RST;
            r_scroll_mode <= SCROLL_MODE_RST;
            r_blank_cnt   <= BLANK_CNT_RST;
            r_show_colon  <= SHOW_COLON_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_SLOT_DUR:    r_slot_dur    <= i_cfg_wr_data;
                CFG_SCROLL_DUR:  r_scroll_dur  <= i_cfg_wr_data;
                CFG_SCROLL_MODE: r_scroll_mode <= i_cfg_wr_data[0];
                CFG_BLANK_CNT:   r_blank_cnt   <= i_cfg_wr_data[7:0];
                CFG_SHOW_COLON:  r_show_colon  <= i_cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    // Shared compare: the tick count against the duration of the current phase.
    assign thresh   = (r_phase == PH_DISPLAY) ? r_slot_dur : r_scroll_dur;
    assign tick_due = (r_tick >= thresh);

    // Shared search step: next slot number with wrap, and the remaining step count.
    always_comb begin
        nx_slot = r_cur + 8'd1;
        if (nx_slot >= 8'(SLOT_COUNT)) begin
            nx_slot = 8'd0;
        end
        nx_left     = r_left - LEFT_W'(1);
        search_stop = slot_enables[nx_slot[IDX_W-1:0]] || (nx_left == '0);
    end

    assign idx_ok    = ({2'b00, r_idx} < 5'(SLOT_COUNT));
    assign search_go = (r_req_type == REQ_TICK) && (r_phase == PH_DISPLAY) && tick_due;

    // Slot store write, taken in the execute cycle.
    always_comb begin
        slot_wr.en      = (r_state == ST_EXEC) && (r_req_type == REQ_WRITE) && idx_ok;
        slot_wr.idx     = r_idx;
        slot_wr.enabled = r_en_in;
        slot_wr.codes   = r_codes_in;
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = search_go ? ST_SEARCH : ST_DONE;
            end
            ST_SEARCH: begin
                if (search_stop) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        o_ready  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
            end
            ST_DONE: begin
                load_out = !r_out_valid || i_ready;
            end
            default: begin
            end
        endcase
    end

    // Display datapath.
    always_comb begin
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_left   = r_left;
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_blanks = r_blanks;
        n_shown  = r_shown;
        case (r_state)
            ST_EXEC: begin
                if (r_req_type == REQ_WRITE) begin
                    // A write to the slot on display refreshes the digits unless scrolling.
                    if (idx_ok && (r_phase == PH_DISPLAY) && ({5'b0, r_idx} == r_cur)) begin
                        n_shown = apply_colon(r_codes_in, r_show_colon);
                    end
                end else begin
                    n_tick = r_tick + TICK_W'(1);
                    if (r_phase == PH_DISPLAY) begin
                        if (tick_due) begin
                            n_tick = TICK_W'(1);
                            n_prev = r_cur;
                            n_left = LEFT_W'(SLOT_COUNT);
                        end
                    end else if (tick_due) begin
                        n_tick = TICK_W'(1);
                        case (r_phase)
                            PH_BLANK: begin
                                n_blanks = (r_blanks != 8'd0) ? r_blanks - 8'd1 : r_blanks;
                                if (n_blanks == 8'd0) begin
                                    n_shown = shift_in(r_shown, slot_codes[0]);
                                    n_phase = PH_DIG1;
                                end else begin
                                    n_shown = shift_in(r_shown, BLANK_CODE);
                                end
                            end
                            PH_DIG1: begin
                                n_shown = shift_in(r_shown, slot_codes[1]);
                                n_phase = PH_DIG2;
                            end
                            PH_DIG2: begin
                                n_shown = shift_in(r_shown, slot_codes[2]);
                                n_phase = PH_DIG3;
                            end
                            PH_DIG3: begin
                                n_shown = apply_colon(shift_in(r_shown, slot_codes[3]),
                                                      r_show_colon);
                                n_phase = PH_DISPLAY;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            ST_SEARCH: begin
                n_cur  = nx_slot;
                n_left = nx_left;
            end
            ST_APPLY: begin
                // Same slot found, or all steps used: the display stays as it is.
                if ((r_prev != r_cur) && (r_left != '0)) begin
                    if (r_scroll_mode) begin
                        n_shown    = shift_in(r_shown, BLANK_CODE);
                        n_shown[0] = r_shown[1] | COLON_BIT;
                        n_blanks   = r_blank_cnt;
                        n_phase    = PH_BLANK;
                    end else begin
                        n_shown = apply_colon(slot_codes, r_show_colon);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control and display state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= NO_SLOT;
            r_left      <= '0;
            r_phase     <= PH_DISPLAY;
            r_tick      <= TICK_RST;
            r_blanks    <= 8'd0;
            r_shown     <= {DIGITS{POWERUP_CODE}};
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_left   <= n_left;
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_blanks <= n_blanks;
            r_shown  <= n_shown;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: the captured transaction, the search origin and the result.
    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        if (o_ready && i_valid) begin
            r_req_type <= i_req_type;
            r_idx      <= i_slot_index;
            r_en_in    <= i_slot_enabled;
            r_codes_in <= {i_slot_code_d, i_slot_code_c, i_slot_code_b, i_slot_code_a};
        end
        if (load_out) begin
            r_out_codes  <= r_shown;
            r_out_scroll <= (r_phase != PH_DISPLAY);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_shown_a   = r_out_codes[0];
    assign o_shown_b   = r_out_codes[1];
    assign o_shown_c   = r_out_codes[2];
    assign o_shown_d   = r_out_codes[3];
    assign o_scrolling = r_out_scroll;

endmodule

// ===== src/srd_checker.sv =====
// Port-level checker for the rotating scroll display controller, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module srd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_shown_a,
    input logic [7:0] o_shown_b,
    input logic [7:0] o_shown_c,
    input logic [7:0] o_shown_d,
    input logic       o_scrolling
);

    // A result that is not taken holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_shown_a) && $stable(o_shown_b)
            && $stable(o_shown_c) && $stable(o_shown_d) && $stable(o_scrolling)))
        else $error("result changed or dropped while stalled");

    // The block works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input still ready after accepting a transaction");

    // A new result appears exactly as the sequencer returns to ready.
    a_result_with_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_ready)
        else $error("result published while the sequencer is busy");

    // Reset leaves the block ready with no result pending.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_ready && !o_valid))
        else $error("reset did not return the block to idle");

endmodule

bind slot_rotating_scroll_display srd_checker u_srd_checker (.*);
